@@ hdl/vt100_pkg.sv @@
// ---------------------------------------------------------------------------
// VT100 parser package
// Action codes, parse states, byte constants and the controller/datapath
// command and status structures.
// ---------------------------------------------------------------------------
package vt100_pkg;

   localparam int MAX_PARAMS_DEFAULT = 10;

   localparam logic [5:0] ACT_PRINT           = 6'd0;
   localparam logic [5:0] ACT_BELL            = 6'd1;
   localparam logic [5:0] ACT_BACKSPACE       = 6'd2;
   localparam logic [5:0] ACT_TAB             = 6'd3;
   localparam logic [5:0] ACT_LINE_FEED       = 6'd4;
   localparam logic [5:0] ACT_CARRIAGE_RETURN = 6'd5;
   localparam logic [5:0] ACT_CURSOR_UP       = 6'd6;
   localparam logic [5:0] ACT_CURSOR_DOWN     = 6'd7;
   localparam logic [5:0] ACT_CURSOR_RIGHT    = 6'd8;
   localparam logic [5:0] ACT_CURSOR_LEFT     = 6'd9;
   localparam logic [5:0] ACT_SET_POS         = 6'd10;
   localparam logic [5:0] ACT_SET_REGION      = 6'd11;
   localparam logic [5:0] ACT_DEVICE_ATTR     = 6'd12;
   localparam logic [5:0] ACT_SAVE_CURSOR     = 6'd13;
   localparam logic [5:0] ACT_RESTORE_CURSOR  = 6'd14;
   localparam logic [5:0] ACT_ATTR_RESET      = 6'd15;
   localparam logic [5:0] ACT_ATTR_UNDERLINE  = 6'd16;
   localparam logic [5:0] ACT_ATTR_BLINK      = 6'd17;
   localparam logic [5:0] ACT_ATTR_INVERSE    = 6'd18;
   localparam logic [5:0] ACT_ATTR_INVISIBLE  = 6'd19;
   localparam logic [5:0] ACT_SET_FG          = 6'd20;
   localparam logic [5:0] ACT_SET_BG          = 6'd21;
   localparam logic [5:0] ACT_CLEAR_TO_END    = 6'd22;
   localparam logic [5:0] ACT_CLEAR_BEG       = 6'd23;
   localparam logic [5:0] ACT_CLEAR_SCREEN    = 6'd24;
   localparam logic [5:0] ACT_CLEAR_TO_EOL    = 6'd25;
   localparam logic [5:0] ACT_CLEAR_LINE_BEG  = 6'd26;
   localparam logic [5:0] ACT_CLEAR_LINE      = 6'd27;
   localparam logic [5:0] ACT_INSERT_LINES    = 6'd28;
   localparam logic [5:0] ACT_DELETE_LINES    = 6'd29;
   localparam logic [5:0] ACT_CLEAR_TAB       = 6'd30;
   localparam logic [5:0] ACT_CLEAR_ALL_TABS  = 6'd31;
   localparam logic [5:0] ACT_STATUS_OK       = 6'd32;
   localparam logic [5:0] ACT_POSITION_REPORT = 6'd33;
   localparam logic [5:0] ACT_REVERSE_INDEX   = 6'd34;
   localparam logic [5:0] ACT_SET_TAB         = 6'd35;
   localparam logic [5:0] ACT_ALIGN_PATTERN   = 6'd36;
   localparam logic [5:0] ACT_TERMINAL_RESET  = 6'd37;
   localparam logic [5:0] ACT_SET_APPCURSOR   = 6'd38;
   localparam logic [5:0] ACT_COLUMN_MODE     = 6'd39;
   localparam logic [5:0] ACT_SET_REVERSE     = 6'd40;
   localparam logic [5:0] ACT_SET_ORIGIN      = 6'd41;
   localparam logic [5:0] ACT_SET_AUTOWRAP    = 6'd42;

   localparam logic [7:0] CHR_C0_MAX  = 8'h1F;
   localparam logic [7:0] CHR_SPACE   = 8'h20;
   localparam logic [7:0] CHR_ZERO    = 8'h30;
   localparam logic [7:0] CHR_QUERY   = 8'h3F;
   localparam logic [7:0] CHR_ESC     = 8'h1B;
   localparam logic [7:0] CHR_CAN     = 8'h18;
   localparam logic [7:0] CHR_SUB     = 8'h1A;
   localparam logic [7:0] CHR_BEL     = 8'h07;
   localparam logic [7:0] SGR_FG_BASE    = 8'd30;
   localparam logic [7:0] SGR_FG_HI_BASE = 8'd90;
   localparam logic [7:0] SGR_BG_BASE    = 8'd40;
   localparam logic [7:0] SGR_BG_HI_BASE = 8'd100;
   localparam logic [7:0] SGR_FG_DEFAULT = 8'd39;
   localparam logic [7:0] SGR_BG_DEFAULT = 8'd49;

   typedef enum logic [2:0] {
      PS_TEXT      = 3'd0,
      PS_ESCAPE    = 3'd1,
      PS_CSI       = 3'd2,
      PS_STRING    = 3'd3,
      PS_SECONDARY = 3'd4,
      PS_CHARSET   = 3'd5,
      PS_HASH      = 3'd6
   } parse_state_type;

   // list expansion kinds
   typedef enum logic [1:0] {
      LIST_NONE = 2'd0,
      LIST_SGR  = 2'd1,
      LIST_PRIV = 2'd2
   } list_kind_type;

   // controller -> datapath
   typedef struct packed {
      logic       clear;     // clear parameters and private flag
      logic       digit;     // accumulate digit into current slot
      logic       next_slot; // ';'
      logic       set_priv;  // '?'
      logic       set_mode;  // h/l flag for private list
      logic [7:0] byte_val;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [7:0] p0;
      logic [7:0] p1;
      logic       priv;
   } dp_status_type;

   function automatic logic is_final(input logic [7:0] c);
      return (c > 8'h40) && (c < 8'h7B);
   endfunction

endpackage

@@ hdl/vt100_escape_sequence_parser_core.sv @@
// ---------------------------------------------------------------------------
// VT100 escape sequence parser core
// Turns received terminal bytes into display action items.
// ---------------------------------------------------------------------------
// Usage:
//  req channel carries one byte (req_rx_byte), accepted when req_valid is high
//  and req_stall low. rsp channel carries action items; rsp_last marks the
//  final item caused by a byte. Bytes that cause nothing produce no item.
//  A single-action byte's item appears on rsp in the cycle after it is accepted.
//  Throughput: one byte per cycle for single-action bytes when rsp does not
//  stall; ESC E and SGR or private-mode lists stall req until done, the list
//  walker reading one parameter slot per cycle when the output is free.
//  Reset clears the parse state, parameters and output register; the block is
//  ready for a byte in the first cycle after reset.
//  When the receiver stalls, the held item stays put and a new byte is taken
//  only if the output register will be free.
// ---------------------------------------------------------------------------
module vt100_escape_sequence_parser_core #(
   parameter int MAX_PARAMS = vt100_pkg::MAX_PARAMS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_action,
   output logic [7:0] rsp_arg_a,
   output logic [7:0] rsp_arg_b,
   output logic       rsp_last
);
   vt100_pkg::dp_cmd_type    cmd;
   vt100_pkg::dp_status_type status;
   vt100_pkg::list_kind_type list_kind;
   logic       list_start, list_step, list_busy, list_hit, list_end, list_more;
   logic [5:0] list_action;
   logic [7:0] list_arg;

   vt100_controller u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_rx_byte,
      .rsp_valid, .rsp_stall, .rsp_action, .rsp_arg_a, .rsp_arg_b, .rsp_last,
      .cmd, .list_start, .list_kind, .list_step, .status,
      .list_busy, .list_hit, .list_end, .list_more, .list_action, .list_arg
   );

   vt100_datapath #(.MAX_PARAMS(MAX_PARAMS)) u_dp (
      .clock, .reset, .cmd, .list_start, .list_kind, .list_step, .status,
      .list_busy, .list_hit, .list_end, .list_more, .list_action, .list_arg
   );
endmodule

@@ hdl/vt100_datapath.sv @@
// ---------------------------------------------------------------------------
// VT100 parser datapath
// Parameter slots, slot index, private flag, and the list expander that
// turns an SGR or private-mode list into actions, one slot per unstalled cycle.
// ---------------------------------------------------------------------------
module vt100_datapath #(
   parameter int MAX_PARAMS = vt100_pkg::MAX_PARAMS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  vt100_pkg::dp_cmd_type    cmd,
   input  logic                     list_start,
   input  vt100_pkg::list_kind_type list_kind,
   input  logic                     list_step,
   output vt100_pkg::dp_status_type status,
   output logic                     list_busy,
   output logic                     list_hit,
   output logic                     list_end,
   output logic                     list_more,
   output logic [5:0]               list_action,
   output logic [7:0]               list_arg
);
   localparam int IW = $clog2(MAX_PARAMS + 1);
   localparam int SW = $clog2(MAX_PARAMS);

   logic [7:0]    values_ff [MAX_PARAMS];
   logic [IW-1:0] index_ff;
   logic          priv_ff;
   logic [IW-1:0] walk_ff, walk_in, count_ff;
   vt100_pkg::list_kind_type kind_ff;
   logic          mode_ff;
   logic [7:0]    v;
   logic [7:0]    cur;
   logic          last_walk;

   function automatic logic slot_hit(vt100_pkg::list_kind_type kind, logic [7:0] val);
      logic hit;
      hit = 1'b0;
      if (kind == vt100_pkg::LIST_SGR)
         hit = (val == 8'd0) || (val == 8'd2) || (val == 8'd4) || (val == 8'd5)
            || (val == 8'd7) || (val == 8'd8)
            || (val == vt100_pkg::SGR_FG_DEFAULT) || (val == vt100_pkg::SGR_BG_DEFAULT)
            || (val >= vt100_pkg::SGR_FG_BASE && val <= vt100_pkg::SGR_FG_BASE + 8'd7)
            || (val >= vt100_pkg::SGR_FG_HI_BASE && val <= vt100_pkg::SGR_FG_HI_BASE + 8'd7)
            || (val >= vt100_pkg::SGR_BG_BASE && val <= vt100_pkg::SGR_BG_BASE + 8'd7)
            || (val >= vt100_pkg::SGR_BG_HI_BASE && val <= vt100_pkg::SGR_BG_HI_BASE + 8'd7);
      else if (kind == vt100_pkg::LIST_PRIV)
         hit = (val == 8'd1) || (val == 8'd3) || (val == 8'd5) || (val == 8'd6)
            || (val == 8'd7);
      return hit;
   endfunction

   assign cur = values_ff[index_ff[SW-1:0]];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < MAX_PARAMS; i++) values_ff[i] <= '0;
         index_ff <= '0;
         priv_ff  <= 1'b0;
      end else begin
         if (cmd.digit)
            values_ff[index_ff[SW-1:0]] <= 8'((cur << 3) + (cur << 1)
               + (cmd.byte_val - vt100_pkg::CHR_ZERO));
         if (cmd.next_slot && (index_ff < IW'(MAX_PARAMS - 1)))
            index_ff <= index_ff + 1'b1;
         if (cmd.set_priv) priv_ff <= 1'b1;
      end
   end

   assign status.p0   = values_ff[0];
   assign status.p1   = values_ff[1];
   assign status.priv = priv_ff;

   // list walker
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= vt100_pkg::LIST_NONE;
         walk_ff <= '0;
      end else if (list_start) begin
         kind_ff  <= list_kind;
         walk_ff  <= '0;
         count_ff <= index_ff + 1'b1;
         mode_ff  <= cmd.set_mode;
      end else if (list_busy && list_step) begin
         walk_ff <= walk_in;
         if (last_walk) kind_ff <= vt100_pkg::LIST_NONE;
      end
   end

   assign walk_in   = walk_ff + 1'b1;
   assign last_walk = (walk_in == count_ff);
   assign list_busy = (kind_ff != vt100_pkg::LIST_NONE);
   assign list_end  = last_walk;
   assign v = values_ff[walk_ff[SW-1:0]];

   always_comb begin
      list_more = 1'b0;
      for (int i = 0; i < MAX_PARAMS; i++)
         if (IW'(i) > walk_ff && IW'(i) < count_ff && slot_hit(kind_ff, values_ff[i]))
            list_more = 1'b1;
   end

   always_comb begin
      list_hit    = 1'b0;
      list_action = vt100_pkg::ACT_PRINT;
      list_arg    = '0;
      if (kind_ff == vt100_pkg::LIST_SGR) begin
         list_hit = 1'b1;
         priority if (v == 8'd0 || v == 8'd2) list_action = vt100_pkg::ACT_ATTR_RESET;
         else if (v == 8'd4) list_action = vt100_pkg::ACT_ATTR_UNDERLINE;
         else if (v == 8'd5) list_action = vt100_pkg::ACT_ATTR_BLINK;
         else if (v == 8'd7) list_action = vt100_pkg::ACT_ATTR_INVERSE;
         else if (v == 8'd8) list_action = vt100_pkg::ACT_ATTR_INVISIBLE;
         else if (v == vt100_pkg::SGR_FG_DEFAULT) begin
            list_action = vt100_pkg::ACT_SET_FG;
            list_arg    = 8'd7;
         end else if (v == vt100_pkg::SGR_BG_DEFAULT) list_action = vt100_pkg::ACT_SET_BG;
         else if (v >= vt100_pkg::SGR_FG_BASE && v <= vt100_pkg::SGR_FG_BASE + 8'd7) begin
            list_action = vt100_pkg::ACT_SET_FG;
            list_arg    = v - vt100_pkg::SGR_FG_BASE;
         end else if (v >= vt100_pkg::SGR_FG_HI_BASE && v <= vt100_pkg::SGR_FG_HI_BASE + 8'd7) begin
            list_action = vt100_pkg::ACT_SET_FG;
            list_arg    = v - vt100_pkg::SGR_FG_HI_BASE;
         end else if (v >= vt100_pkg::SGR_BG_BASE && v <= vt100_pkg::SGR_BG_BASE + 8'd7) begin
            list_action = vt100_pkg::ACT_SET_BG;
            list_arg    = v - vt100_pkg::SGR_BG_BASE;
         end else if (v >= vt100_pkg::SGR_BG_HI_BASE && v <= vt100_pkg::SGR_BG_HI_BASE + 8'd7) begin
            list_action = vt100_pkg::ACT_SET_BG;
            list_arg    = v - vt100_pkg::SGR_BG_HI_BASE;
         end else list_hit = 1'b0;
      end else if (kind_ff == vt100_pkg::LIST_PRIV) begin
         list_hit = 1'b1;
         list_arg = {7'd0, mode_ff};
         unique case (v)
            8'd1:    list_action = vt100_pkg::ACT_SET_APPCURSOR;
            8'd3:    list_action = vt100_pkg::ACT_COLUMN_MODE;
            8'd5:    list_action = vt100_pkg::ACT_SET_REVERSE;
            8'd6:    list_action = vt100_pkg::ACT_SET_ORIGIN;
            8'd7:    list_action = vt100_pkg::ACT_SET_AUTOWRAP;
            default: list_hit    = 1'b0;
         endcase
      end
   end

   no_slot_overrun: assert property (@(posedge clock) disable iff (reset)
      index_ff <= IW'(MAX_PARAMS - 1))
      else $error("parameter slot index past last slot");
   walk_in_range: assert property (@(posedge clock) disable iff (reset)
      list_busy |-> walk_ff < count_ff)
      else $error("list walker beyond parameter count");
   no_clear_while_walking: assert property (@(posedge clock) disable iff (reset)
      list_busy |-> !cmd.digit)
      else $error("parameter written during list expansion");
endmodule

@@ hdl/vt100_controller.sv @@
// ---------------------------------------------------------------------------
// VT100 parser controller
// Decodes each byte against the parse state, drives datapath commands and
// the output register, and sequences ESC E and list expansion.
// ---------------------------------------------------------------------------
module vt100_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [5:0]               rsp_action,
   output logic [7:0]               rsp_arg_a,
   output logic [7:0]               rsp_arg_b,
   output logic                     rsp_last,
   output vt100_pkg::dp_cmd_type    cmd,
   output logic                     list_start,
   output vt100_pkg::list_kind_type list_kind,
   output logic                     list_step,
   input  vt100_pkg::dp_status_type status,
   input  logic                     list_busy,
   input  logic                     list_hit,
   input  logic                     list_end,
   input  logic                     list_more,
   input  logic [5:0]               list_action,
   input  logic [7:0]               list_arg
);
   typedef enum logic [1:0] {
      C_IDLE  = 2'd0,
      C_NEL   = 2'd1,
      C_LIST  = 2'd2
   } ctl_type;

   ctl_type                    ctl_ff;
   vt100_pkg::parse_state_type ps_ff, ps_in;
   logic       ov_ff;
   logic [5:0] act_ff;
   logic [7:0] a_ff, b_ff;
   logic       last_ff;

   logic       accept, out_free, out_load;
   logic       e_valid, e_last, go_nel, go_list;
   logic [5:0] e_act;
   logic [7:0] e_a, e_b;
   logic [7:0] c, p0, p1, n;
   logic       c0_in_seq;

   assign out_free = !ov_ff || !rsp_stall;
   assign req_stall = (ctl_ff != C_IDLE) || !out_free;
   assign accept = req_valid && !req_stall;
   assign c  = req_rx_byte;
   assign p0 = status.p0;
   assign p1 = status.p1;
   assign n  = (p0 == 8'd0) ? 8'd1 : p0;
   assign c0_in_seq = (c <= vt100_pkg::CHR_C0_MAX) && (ps_ff == vt100_pkg::PS_ESCAPE
      || ps_ff == vt100_pkg::PS_CSI || ps_ff == vt100_pkg::PS_SECONDARY);

   always_comb begin
      ps_in     = ps_ff;
      e_valid   = 1'b0;
      e_act     = vt100_pkg::ACT_PRINT;
      e_a       = '0;
      e_b       = '0;
      e_last    = 1'b1;
      go_nel    = 1'b0;
      go_list   = 1'b0;
      list_kind = vt100_pkg::LIST_NONE;
      cmd       = '0;
      cmd.byte_val = c;
      cmd.set_mode = (c == "h");
      if (c0_in_seq || ps_ff == vt100_pkg::PS_TEXT) begin
         if (c == vt100_pkg::CHR_ESC) begin
            ps_in = vt100_pkg::PS_ESCAPE;
            cmd.clear = 1'b1;
         end else if (c0_in_seq && (c == vt100_pkg::CHR_CAN || c == vt100_pkg::CHR_SUB)) begin
            ps_in = vt100_pkg::PS_TEXT;
            cmd.clear = 1'b1;
         end else if (c >= vt100_pkg::CHR_SPACE && c < 8'h80) begin
            e_valid = 1'b1;
            e_a     = c;
         end else begin
            e_valid = 1'b1;
            unique case (c)
               8'h07:               e_act = vt100_pkg::ACT_BELL;
               8'h08:               e_act = vt100_pkg::ACT_BACKSPACE;
               8'h09:               e_act = vt100_pkg::ACT_TAB;
               8'h0A, 8'h0B, 8'h0C: e_act = vt100_pkg::ACT_LINE_FEED;
               8'h0D:               e_act = vt100_pkg::ACT_CARRIAGE_RETURN;
               default:             e_valid = 1'b0;
            endcase
         end
      end else begin
         unique case (ps_ff)
            vt100_pkg::PS_ESCAPE: begin
               ps_in = vt100_pkg::PS_TEXT;
               if (c == "[") ps_in = vt100_pkg::PS_CSI;
               else if (c == "]" || c == "P" || c == "^" || c == "_")
                  ps_in = vt100_pkg::PS_STRING;
               else if (c == "(" || c == ")" || c == "*" || c == "+")
                  ps_in = vt100_pkg::PS_CHARSET;
               else if (c == "#") ps_in = vt100_pkg::PS_HASH;
               else if (c == "7") begin
                  e_valid = 1'b1; e_act = vt100_pkg::ACT_SAVE_CURSOR;
               end else if (c == "8") begin
                  e_valid = 1'b1; e_act = vt100_pkg::ACT_RESTORE_CURSOR;
               end else if (c == "c") begin
                  cmd.clear = 1'b1;
                  e_valid = 1'b1; e_act = vt100_pkg::ACT_TERMINAL_RESET;
               end else if (vt100_pkg::is_final(c)) begin
                  cmd.clear = 1'b1;
                  if (c == "D") begin
                     e_valid = 1'b1; e_act = vt100_pkg::ACT_LINE_FEED;
                  end else if (c == "M") begin
                     e_valid = 1'b1; e_act = vt100_pkg::ACT_REVERSE_INDEX;
                  end else if (c == "E") begin
                     e_valid = 1'b1; e_act = vt100_pkg::ACT_CARRIAGE_RETURN;
                     e_last = 1'b0; go_nel = 1'b1;
                  end else if (c == "H") begin
                     e_valid = 1'b1; e_act = vt100_pkg::ACT_SET_TAB;
                  end
               end
            end
            vt100_pkg::PS_CSI: begin
               if (c == vt100_pkg::CHR_QUERY) cmd.set_priv = 1'b1;
               else if (c == ">" || c == "=") ps_in = vt100_pkg::PS_SECONDARY;
               else if (c >= "0" && c <= "9") cmd.digit = 1'b1;
               else if (c == ";") cmd.next_slot = 1'b1;
               else if (vt100_pkg::is_final(c)) begin
                  ps_in = vt100_pkg::PS_TEXT;
                  if (status.priv) begin
                     if (c == "h" || c == "l") begin
                        go_list = 1'b1; list_kind = vt100_pkg::LIST_PRIV;
                     end else cmd.clear = 1'b1;
                  end else if (c == "m") begin
                     go_list = 1'b1; list_kind = vt100_pkg::LIST_SGR;
                  end else begin
                     cmd.clear = 1'b1;
                     e_valid = 1'b1;
                     priority case (c)
                        "A": begin e_act = vt100_pkg::ACT_CURSOR_UP;    e_a = n; end
                        "B": begin e_act = vt100_pkg::ACT_CURSOR_DOWN;  e_a = n; end
                        "C": begin e_act = vt100_pkg::ACT_CURSOR_RIGHT; e_a = n; end
                        "D": begin e_act = vt100_pkg::ACT_CURSOR_LEFT;  e_a = n; end
                        "H", "f": begin
                           e_act = vt100_pkg::ACT_SET_POS;
                           e_a = ((p1 == 8'd0) ? 8'd1 : p1) - 8'd1;
                           e_b = n - 8'd1;
                        end
                        "r": begin e_act = vt100_pkg::ACT_SET_REGION; e_a = p0; e_b = p1; end
                        "c": e_act = vt100_pkg::ACT_DEVICE_ATTR;
                        "s": e_act = vt100_pkg::ACT_SAVE_CURSOR;
                        "u": e_act = vt100_pkg::ACT_RESTORE_CURSOR;
                        "J": begin
                           if (p0 == 8'd0) e_act = vt100_pkg::ACT_CLEAR_TO_END;
                           else if (p0 == 8'd1) e_act = vt100_pkg::ACT_CLEAR_BEG;
                           else if (p0 == 8'd2) e_act = vt100_pkg::ACT_CLEAR_SCREEN;
                           else e_valid = 1'b0;
                        end
                        "K": begin
                           if (p0 == 8'd0) e_act = vt100_pkg::ACT_CLEAR_TO_EOL;
                           else if (p0 == 8'd1) e_act = vt100_pkg::ACT_CLEAR_LINE_BEG;
                           else if (p0 == 8'd2) e_act = vt100_pkg::ACT_CLEAR_LINE;
                           else e_valid = 1'b0;
                        end
                        "L": begin e_act = vt100_pkg::ACT_INSERT_LINES; e_a = n; end
                        "M": begin e_act = vt100_pkg::ACT_DELETE_LINES; e_a = n; end
                        "g": begin
                           if (p0 == 8'd0) e_act = vt100_pkg::ACT_CLEAR_TAB;
                           else if (p0 == 8'd3) e_act = vt100_pkg::ACT_CLEAR_ALL_TABS;
                           else e_valid = 1'b0;
                        end
                        "n": begin
                           if (p0 == 8'd5) e_act = vt100_pkg::ACT_STATUS_OK;
                           else if (p0 == 8'd6) e_act = vt100_pkg::ACT_POSITION_REPORT;
                           else e_valid = 1'b0;
                        end
                        default: e_valid = 1'b0;
                     endcase
                  end
               end else begin
                  ps_in = vt100_pkg::PS_TEXT;
                  cmd.clear = 1'b1;
               end
            end
            vt100_pkg::PS_STRING: begin
               if (c == vt100_pkg::CHR_BEL) ps_in = vt100_pkg::PS_TEXT;
               else if (c == vt100_pkg::CHR_ESC) begin
                  ps_in = vt100_pkg::PS_ESCAPE; cmd.clear = 1'b1;
               end
            end
            vt100_pkg::PS_SECONDARY: begin
               if (vt100_pkg::is_final(c)) begin
                  ps_in = vt100_pkg::PS_TEXT; cmd.clear = 1'b1;
               end
            end
            vt100_pkg::PS_CHARSET: ps_in = vt100_pkg::PS_TEXT;
            vt100_pkg::PS_HASH: begin
               ps_in = vt100_pkg::PS_TEXT;
               if (c == "8") begin
                  e_valid = 1'b1; e_act = vt100_pkg::ACT_ALIGN_PATTERN;
               end
            end
            default: begin
               ps_in = vt100_pkg::PS_TEXT; cmd.clear = 1'b1;
            end
         endcase
      end
      if (!accept) begin
         cmd.clear = 1'b0; cmd.digit = 1'b0; cmd.next_slot = 1'b0; cmd.set_priv = 1'b0;
      end
      // finish the list
      if (ctl_ff == C_LIST && list_step && list_end) cmd.clear = 1'b1;
   end

   assign list_start = accept && go_list;
   assign list_step  = (ctl_ff == C_LIST) && out_free;
   assign out_load   = (accept && e_valid) || (ctl_ff == C_NEL && out_free)
      || (ctl_ff == C_LIST && out_free && list_hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= C_IDLE;
         ps_ff  <= vt100_pkg::PS_TEXT;
         ov_ff  <= 1'b0;
      end else begin
         if (out_load) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
         unique case (ctl_ff)
            C_IDLE: if (accept) begin
               ps_ff <= ps_in;
               if (e_valid) begin
                  act_ff <= e_act; a_ff <= e_a; b_ff <= e_b;
                  last_ff <= e_last;
               end
               if (go_nel) ctl_ff <= C_NEL;
               else if (go_list) ctl_ff <= C_LIST;
            end
            C_NEL: if (out_free) begin
               act_ff <= vt100_pkg::ACT_LINE_FEED;
               a_ff <= '0; b_ff <= '0; last_ff <= 1'b1;
               ctl_ff <= C_IDLE;
            end
            C_LIST: if (out_free) begin
               if (list_hit) begin
                  act_ff <= list_action; a_ff <= list_arg;
                  b_ff <= '0; last_ff <= !list_more;
               end
               if (list_end) ctl_ff <= C_IDLE;
            end
            default: ctl_ff <= C_IDLE;
         endcase
      end
   end

   assign rsp_valid  = ov_ff;
   assign rsp_action = act_ff;
   assign rsp_arg_a  = a_ff;
   assign rsp_arg_b  = b_ff;
   assign rsp_last   = last_ff;

   busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff != C_IDLE) |-> req_stall)
      else $error("input taken during multi-action expansion");
   list_follows_walker: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff == C_LIST) |-> list_busy)
      else $error("controller and list walker out of step");
   nel_line_feed: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff == C_NEL && out_free) |=> (rsp_valid && rsp_action == vt100_pkg::ACT_LINE_FEED))
      else $error("next-line pair broken");
endmodule
